@@ sv/lps_pkg.sv @@
package lps_pkg;

    // phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ON   = 2'd1;
    localparam logic [1:0] PH_OFF  = 2'd2;

    // transaction kinds
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_CMD  = 1'b1;

    // highest code that names a pattern
    localparam logic [3:0] CODE_MAX = 4'd13;

    localparam int          TIME_WIDTH_DEF = 11;
    localparam logic [7:0]  SLICE_RESET    = 8'd50;

    typedef struct packed {
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [10:0] on_ms;
        logic [10:0] off_ms;
        logic [2:0]  cycles;
    } t_pattern;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       busy_res;
        logic       pending_flag;
    } t_result;

    // fixed pattern table
    function automatic t_pattern pattern_lookup(input logic [3:0] code);
        t_pattern p;
        case (code)
            4'd1:    p = '{8'd255, 8'd255, 8'd255, 11'd500,  11'd500,  3'd3};
            4'd2:    p = '{8'd0,   8'd0,   8'd255, 11'd350,  11'd250,  3'd3};
            4'd3:    p = '{8'd0,   8'd255, 8'd0,   11'd200,  11'd150,  3'd1};
            4'd4:    p = '{8'd0,   8'd255, 8'd0,   11'd2000, 11'd0,    3'd1};
            4'd5:    p = '{8'd0,   8'd255, 8'd0,   11'd1000, 11'd0,    3'd1};
            4'd6:    p = '{8'd0,   8'd255, 8'd0,   11'd1000, 11'd1000, 3'd3};
            4'd7:    p = '{8'd255, 8'd180, 8'd0,   11'd350,  11'd250,  3'd3};
            4'd8:    p = '{8'd255, 8'd180, 8'd0,   11'd150,  11'd100,  3'd6};
            4'd9:    p = '{8'd255, 8'd0,   8'd255, 11'd350,  11'd250,  3'd3};
            4'd10:   p = '{8'd255, 8'd0,   8'd255, 11'd150,  11'd100,  3'd6};
            4'd11:   p = '{8'd255, 8'd0,   8'd0,   11'd350,  11'd250,  3'd3};
            4'd12:   p = '{8'd255, 8'd0,   8'd0,   11'd250,  11'd250,  3'd3};
            4'd13:   p = '{8'd255, 8'd165, 8'd0,   11'd250,  11'd250,  3'd5};
            default: p = '{8'd0,   8'd0,   8'd0,   11'd0,    11'd0,    3'd0};
        endcase
        return p;
    endfunction

endpackage

@@ sv/lps_if.sv @@
interface lps_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [3:0] command_code;

    modport source (output valid, output op, output command_code, input ready);
    modport sink (input valid, input op, input command_code, output ready);
endinterface

interface lps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       busy_res;
    logic       pending_flag;

    modport source (output valid, output red, output green, output blue,
                    output busy_res, output pending_flag, input ready);
    modport sink (input valid, input red, input green, input blue,
                  input busy_res, input pending_flag, output ready);
endinterface

interface lps_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] slice_length;

    modport source (output valid, output slice_length, input ready);
    modport sink (input valid, input slice_length, output ready);
endinterface

@@ sv/lps_core.sv @@
module lps_core #(
    parameter int TIME_WIDTH = lps_pkg::TIME_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_op,
    input  logic [3:0]      i_code,
    input  logic [7:0]      i_slice_len,
    output lps_pkg::t_result o_result
);
    import lps_pkg::*;

    logic [3:0]            r_active, n_active;
    logic [1:0]            r_phase, n_phase;
    logic [TIME_WIDTH-1:0] r_time_left, n_time_left;
    logic [7:0]            r_slice, n_slice;
    logic [2:0]            r_repeats, n_repeats;
    logic                  r_pend_valid, n_pend_valid;
    logic [3:0]            r_pend_code, n_pend_code;

    logic     busy;
    t_pattern cur_pat;
    t_pattern st_pat;
    t_pattern out_pat;
    logic     do_start;
    logic [3:0] st_code;
    logic [TIME_WIDTH-1:0] dec_time;
    logic     boundary;

    assign busy    = (r_phase == PH_ON) || (r_phase == PH_OFF);
    assign cur_pat = pattern_lookup(r_active);
    assign st_pat  = pattern_lookup(st_code);

    // next state for one transaction
    always_comb begin
        n_active     = r_active;
        n_phase      = r_phase;
        n_time_left  = r_time_left;
        n_slice      = r_slice;
        n_repeats    = r_repeats;
        n_pend_valid = r_pend_valid;
        n_pend_code  = r_pend_code;
        do_start     = 1'b0;
        st_code      = i_code;
        dec_time     = (r_time_left != '0) ? r_time_left - 1'b1 : r_time_left;
        boundary     = ({1'b0, r_slice} + 9'd1 >= {1'b0, i_slice_len}) || (dec_time == '0);

        if (i_accept) begin
            if (i_op == OP_CMD) begin
                if (i_code <= CODE_MAX) begin
                    if (busy) begin
                        n_pend_valid = 1'b1;
                        n_pend_code  = i_code;
                    end else begin
                        do_start = 1'b1;
                    end
                end
            end else if (busy) begin
                n_time_left = dec_time;
                n_slice     = r_slice + 8'd1;
                if (boundary) begin
                    n_slice = 8'd0;
                    if (r_pend_valid) begin
                        // abort the running pattern
                        n_pend_valid = 1'b0;
                        do_start     = 1'b1;
                        st_code      = r_pend_code;
                    end else if (dec_time == '0) begin
                        if (r_phase == PH_ON && cur_pat.off_ms != '0) begin
                            n_phase     = PH_OFF;
                            n_time_left = TIME_WIDTH'(cur_pat.off_ms);
                        end else begin
                            n_repeats = r_repeats - 3'd1;
                            if (n_repeats == 3'd0) begin
                                n_phase     = PH_IDLE;
                                n_time_left = '0;
                            end else begin
                                n_phase     = PH_ON;
                                n_time_left = TIME_WIDTH'(cur_pat.on_ms);
                            end
                        end
                    end
                end
            end
        end

        // start a pattern from its table entry
        if (do_start) begin
            n_active = st_code;
            n_slice  = 8'd0;
            if (st_pat.cycles == 3'd0) begin
                n_phase     = PH_IDLE;
                n_time_left = '0;
                n_repeats   = 3'd0;
            end else begin
                n_phase     = PH_ON;
                n_time_left = TIME_WIDTH'(st_pat.on_ms);
                n_repeats   = st_pat.cycles;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 4'd0;
            r_phase      <= PH_IDLE;
            r_time_left  <= '0;
            r_slice      <= 8'd0;
            r_repeats    <= 3'd0;
            r_pend_valid <= 1'b0;
            r_pend_code  <= 4'd0;
        end else begin
            r_active     <= n_active;
            r_phase      <= n_phase;
            r_time_left  <= n_time_left;
            r_slice      <= n_slice;
            r_repeats    <= n_repeats;
            r_pend_valid <= n_pend_valid;
            r_pend_code  <= n_pend_code;
        end
    end

    // result as seen after the update
    assign out_pat = pattern_lookup(n_active);
    always_comb begin
        o_result.red          = (n_phase == PH_ON) ? out_pat.r : 8'd0;
        o_result.green        = (n_phase == PH_ON) ? out_pat.g : 8'd0;
        o_result.blue         = (n_phase == PH_ON) ? out_pat.b : 8'd0;
        o_result.busy_res     = (n_phase == PH_ON) || (n_phase == PH_OFF);
        o_result.pending_flag = n_pend_valid;
    end

`ifndef SYNTH
    a_pend_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_phase == PH_ON || r_phase == PH_OFF))
        else $error("pending command held while idle");

    a_idle_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_repeats == 3'd0 && r_time_left == '0))
        else $error("idle with counters left over");

    a_busy_repeats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ON || r_phase == PH_OFF) |-> (r_repeats != 3'd0))
        else $error("pattern running with no repeats left");

    a_no_change_unaccepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_accept) && $past(i_rst_n) |-> $stable(r_phase) && $stable(r_pend_valid))
        else $error("state moved without a transaction");
`endif

endmodule

@@ sv/led_pattern_sequencer.sv @@
// channel  | direction | handshake    | payload
// i_in     | in        | valid/ready  | op, command_code
// o_out    | out       | valid/ready  | red, green, blue, busy_res, pending_flag
// i_cfg    | in        | valid/ready  | slice_length
//
// one transaction is taken per cycle while i_in.ready is high; its result is
// held in the output register, set by the single next-state stage in lps_core
// i_in.ready drops only while a result waits in o_out and o_out.ready is low
// i_cfg.ready is always high
// synchronous active-low reset: idle, no pending command, slice_length 50
module led_pattern_sequencer #(
    parameter int TIME_WIDTH = lps_pkg::TIME_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lps_in_if.sink    i_in,
    lps_out_if.source o_out,
    lps_cfg_if.sink   i_cfg
);
    import lps_pkg::*;

    logic [7:0] r_slice_len;
    logic       r_out_valid;
    t_result    r_out;
    t_result    core_result;
    logic       in_accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && i_in.ready;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_len <= SLICE_RESET;
        end else if (i_cfg.valid) begin
            r_slice_len <= i_cfg.slice_length;
        end
    end

    lps_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_op        (i_in.op),
        .i_code      (i_in.command_code),
        .i_slice_len (r_slice_len),
        .o_result    (core_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= core_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.red          = r_out.red;
    assign o_out.green        = r_out.green;
    assign o_out.blue         = r_out.blue;
    assign o_out.busy_res     = r_out.busy_res;
    assign o_out.pending_flag = r_out.pending_flag;

endmodule

@@ tb/sv/led_pattern_sequencer_tb.sv @@
`timescale 1ns / 100ps

module led_pattern_sequencer_tb;

    import lps_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_STALL  = 300;
    localparam int DRAIN_TAIL  = 4;

    // blink table: colour, on time, off time, repeat count
    localparam t_pattern BLINK_TABLE [16] = '{
        '{8'd0,   8'd0,   8'd0,   11'd0,    11'd0,    3'd0},
        '{8'd255, 8'd255, 8'd255, 11'd500,  11'd500,  3'd3},
        '{8'd0,   8'd0,   8'd255, 11'd350,  11'd250,  3'd3},
        '{8'd0,   8'd255, 8'd0,   11'd200,  11'd150,  3'd1},
        '{8'd0,   8'd255, 8'd0,   11'd2000, 11'd0,    3'd1},
        '{8'd0,   8'd255, 8'd0,   11'd1000, 11'd0,    3'd1},
        '{8'd0,   8'd255, 8'd0,   11'd1000, 11'd1000, 3'd3},
        '{8'd255, 8'd180, 8'd0,   11'd350,  11'd250,  3'd3},
        '{8'd255, 8'd180, 8'd0,   11'd150,  11'd100,  3'd6},
        '{8'd255, 8'd0,   8'd255, 11'd350,  11'd250,  3'd3},
        '{8'd255, 8'd0,   8'd255, 11'd150,  11'd100,  3'd6},
        '{8'd255, 8'd0,   8'd0,   11'd350,  11'd250,  3'd3},
        '{8'd255, 8'd0,   8'd0,   11'd250,  11'd250,  3'd3},
        '{8'd255, 8'd165, 8'd0,   11'd250,  11'd250,  3'd5},
        '{8'd0,   8'd0,   8'd0,   11'd0,    11'd0,    3'd0},
        '{8'd0,   8'd0,   8'd0,   11'd0,    11'd0,    3'd0}
    };

    // short patterns whose phases can run out within one traffic burst
    localparam logic [3:0] SHORT_PATTERNS [4] = '{4'd3, 4'd8, 4'd10, 4'd12};

    logic i_clk;
    logic i_rst_n;

    lps_in_if  in_ch ();
    lps_out_if out_ch ();
    lps_cfg_if cfg_ch ();

    led_pattern_sequencer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // sequencer state as predicted
    logic [7:0]  seq_slice_len;
    logic [3:0]  seq_pattern;
    logic [1:0]  seq_phase;
    logic [10:0] seq_time_left;
    logic [7:0]  seq_slice_t;
    logic [2:0]  seq_repeats;
    logic        seq_pend_valid;
    logic [3:0]  seq_pend_code;

    t_result led_view_q [$];
    t_result led_view_want;

    int errors;
    int cycle_count;
    int items_sent;
    int results_checked;
    int patterns_done;
    int aborts_seen;
    int src_idle_pct;
    int snk_idle_pct;
    int stall_asks;
    int stall_grants;
    int hold_left;

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: watchdog expired after %0d cycles", $time, cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // load a pattern and enter its first on-phase
    function automatic void begin_pattern(input logic [3:0] code);
        t_pattern p;
        p = BLINK_TABLE[code];
        seq_pattern = code;
        seq_slice_t = '0;
        if (p.cycles == '0) begin
            seq_phase     = PH_IDLE;
            seq_time_left = '0;
            seq_repeats   = '0;
        end else begin
            seq_phase     = PH_ON;
            seq_time_left = p.on_ms;
            seq_repeats   = p.cycles;
        end
    endfunction

    // one millisecond of pattern time
    function automatic void advance_one_ms();
        t_pattern p;
        logic     at_boundary;
        p = BLINK_TABLE[seq_pattern];
        if (seq_phase != PH_ON && seq_phase != PH_OFF)
            return;
        if (seq_time_left != '0)
            seq_time_left = seq_time_left - 11'd1;
        at_boundary = (int'(seq_slice_t) + 1 >= int'(seq_slice_len)) || (seq_time_left == '0);
        seq_slice_t = seq_slice_t + 8'd1;
        if (!at_boundary)
            return;
        seq_slice_t = '0;
        // a waiting command aborts the pattern here
        if (seq_pend_valid) begin
            seq_pend_valid = 1'b0;
            aborts_seen++;
            begin_pattern(seq_pend_code);
            return;
        end
        if (seq_time_left != '0)
            return;
        if (seq_phase == PH_ON && p.off_ms != '0) begin
            seq_phase     = PH_OFF;
            seq_time_left = p.off_ms;
        end else begin
            seq_repeats = seq_repeats - 3'd1;
            if (seq_repeats == '0) begin
                seq_phase     = PH_IDLE;
                seq_time_left = '0;
                patterns_done++;
            end else begin
                seq_phase     = PH_ON;
                seq_time_left = p.on_ms;
            end
        end
    endfunction

    // LED outputs after one input transaction
    function automatic t_result next_led_view(input logic op, input logic [3:0] code);
        t_pattern p;
        t_result  r;
        if (op == OP_CMD) begin
            if (code <= CODE_MAX) begin
                if (seq_phase == PH_ON || seq_phase == PH_OFF) begin
                    seq_pend_valid = 1'b1;
                    seq_pend_code  = code;
                end else begin
                    begin_pattern(code);
                end
            end
        end else begin
            advance_one_ms();
        end
        p = BLINK_TABLE[seq_pattern];
        r.busy_res     = (seq_phase == PH_ON || seq_phase == PH_OFF);
        r.red          = (seq_phase == PH_ON) ? p.r : 8'd0;
        r.green        = (seq_phase == PH_ON) ? p.g : 8'd0;
        r.blue         = (seq_phase == PH_ON) ? p.b : 8'd0;
        r.pending_flag = seq_pend_valid;
        return r;
    endfunction

    task automatic compare_channel(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // transaction monitor: checks results, feeds the predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_slice_len  = SLICE_RESET;
            seq_pattern    = '0;
            seq_phase      = PH_IDLE;
            seq_time_left  = '0;
            seq_slice_t    = '0;
            seq_repeats    = '0;
            seq_pend_valid = 1'b0;
            seq_pend_code  = '0;
            led_view_q.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (led_view_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected, actual %0d/%0d/%0d busy %0b pend %0b",
                             $time, out_ch.red, out_ch.green, out_ch.blue,
                             out_ch.busy_res, out_ch.pending_flag);
                end else begin
                    led_view_want = led_view_q.pop_front();
                    results_checked++;
                    compare_channel("red", led_view_want.red, out_ch.red);
                    compare_channel("green", led_view_want.green, out_ch.green);
                    compare_channel("blue", led_view_want.blue, out_ch.blue);
                    compare_channel("busy_res", led_view_want.busy_res, out_ch.busy_res);
                    compare_channel("pending_flag", led_view_want.pending_flag,
                                    out_ch.pending_flag);
                end
            end
            if (in_ch.valid && in_ch.ready)
                led_view_q.push_back(next_led_view(in_ch.op, in_ch.command_code));
            if (cfg_ch.valid && cfg_ch.ready)
                seq_slice_len = cfg_ch.slice_length;
        end
    end

    // result receiver: random idling, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (stall_grants != stall_asks) begin
            stall_grants = stall_asks;
            hold_left    = LONG_STALL;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // offer one transaction, with a random gap first
    task automatic send_item(input logic op, input logic [3:0] code);
        if ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_ch.valid        <= 1'b1;
        in_ch.op           <= op;
        in_ch.command_code <= code;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic send_command(input int code);
        send_item(OP_CMD, 4'(code));
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 4'($urandom_range(15)));
    endtask

    task automatic write_slice(input int len);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.slice_length <= 8'(len);
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (led_view_q.size() != 0);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // ticks while idle, unknown codes and the off code leave the LED dark
    task automatic test_idle_and_unknown();
        send_tick();
        send_command(14);
        send_command(15);
        send_command(0);
        send_tick();
    endtask

    // commands during a pattern become pending, the newest valid code wins
    task automatic test_pending_replace();
        send_command(1);
        send_tick();
        send_command(2);
        send_command(13);
        send_command(14);
        repeat (3) send_tick();
        settle();
    endtask

    // with a one millisecond slice every tick is a boundary
    task automatic test_slice_abort();
        write_slice(1);
        send_tick();
        send_command(4);
        send_tick();
        send_command(5);
        send_tick();
        send_command(0);
        send_tick();
        send_command(12);
        send_command(9);
        send_command(0);
        send_tick();
        send_tick();
        settle();
    endtask

    // bursts: a command followed by ticks, some long enough to finish phases
    task automatic test_blink_traffic(input int slice, input int src_pct, input int snk_pct,
                                      input int count);
        int         sent;
        int         run;
        logic [3:0] code;
        bit         long_burst;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        write_slice(slice);
        sent = 0;
        while (sent < count) begin
            long_burst = ($urandom_range(99) < 30);
            if (long_burst) begin
                code = SHORT_PATTERNS[$urandom_range(3)];
                run  = $urandom_range(300, 480);
            end else begin
                code = 4'($urandom_range(15));
                run  = $urandom_range(40);
            end
            send_command(code);
            sent++;
            // keep the last burst within the budget
            if (run > count - sent)
                run = count - sent;
            repeat (run) begin
                if (!long_burst && $urandom_range(99) < 10)
                    send_command($urandom_range(15));
                else
                    send_tick();
                sent++;
            end
        end
        settle();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_output_stall();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_slice(3);
        stall_asks++;
        send_command(8);
        repeat (70) begin
            if ($urandom_range(99) < 10)
                send_command($urandom_range(15));
            else
                send_tick();
        end
        settle();
    endtask

    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.op            = OP_TICK;
        in_ch.command_code  = '0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.slice_length = SLICE_RESET;
        errors              = 0;
        cycle_count         = 0;
        items_sent          = 0;
        results_checked     = 0;
        patterns_done       = 0;
        aborts_seen         = 0;
        stall_asks          = 0;
        stall_grants        = 0;
        hold_left           = 0;
        src_idle_pct        = 16;
        snk_idle_pct        = 54;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_and_unknown();
        test_pending_replace();
        test_slice_abort();
        test_blink_traffic(255, 16, 54, 440);
        test_blink_traffic($urandom_range(2, 254), 54, 16, 440);
        test_blink_traffic(1, 0, 0, 440);
        test_output_stall();

        if (led_view_q.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, led_view_q.size());
        end

        $display("%0d transactions sent, %0d results checked, %0d mismatches",
                 items_sent, results_checked, errors);
        $display("%0d patterns ran to completion, %0d pending commands took over",
                 patterns_done, aborts_seen);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
